@@ rtl/core/atw_pkg.sv @@
// Shared types and constants of the animation time wrapper.
`default_nettype none

package atw_pkg;

  localparam int TIME_BITS_DEFAULT     = 32;
  localparam int FRACTION_BITS_DEFAULT = 16;

  // Sentinel values that mark an unset key range (raw 32-bit register contents).
  localparam logic [31:0] KEY_START_UNSET = 32'h7FFF_FFFF;
  localparam logic [31:0] KEY_STOP_UNSET  = 32'h8000_0000;

  localparam logic [1:0] MODE_WRAP     = 2'd0;
  localparam logic [1:0] MODE_PINGPONG = 2'd1;
  localparam logic [1:0] MODE_HOLD     = 2'd2;

  typedef enum logic [2:0] {
    CFG_FREQUENCY      = 3'd0,
    CFG_PHASE          = 3'd1,
    CFG_KEY_START      = 3'd2,
    CFG_KEY_STOP       = 3'd3,
    CFG_CYCLE_MODE     = 3'd4,
    CFG_PLAY_BACKWARDS = 3'd5,
    CFG_ACTIVE         = 3'd6,
    CFG_COMPUTE_SCALED = 3'd7
  } atw_cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_MSETUP,
    S_MUL,
    S_MFIX,
    S_WACC,
    S_PHASE,
    S_WSEL,
    S_DSETUP,
    S_DIV,
    S_RSIGN,
    S_POST1,
    S_POST2,
    S_POST3,
    S_CLAMP,
    S_MIR1,
    S_MIR2,
    S_CMP,
    S_DONE
  } atw_state_e;

endpackage

`default_nettype wire

@@ rtl/core/atw_mul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module atw_mul import atw_pkg::*; #(
  parameter int W = TIME_BITS_DEFAULT
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   mcand_i,
  input  wire logic [W-1:0]   mplier_i,
  output logic                done_o,
  output logic [2*W-1:0]      prod_o
);

  localparam int CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  mcand_q;
  logic [W-1:0]  hi_q;
  logic [W-1:0]  lo_q;
  logic [W:0]    sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Add the multiplicand on a set bit, then shift the whole product right.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[W:1];
      lo_q <= {sum[0], lo_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

@@ rtl/core/atw_rem.sv @@
// Bit-serial restoring remainder of two unsigned magnitudes, one bit per cycle.
`default_nettype none

module atw_rem import atw_pkg::*; #(
  parameter int W = TIME_BITS_DEFAULT
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      rem_o
);

  localparam int CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  dvd_q;
  logic [W-1:0]  dvs_q;
  logic [W-1:0]  rem_q;
  logic [W:0]    trial;
  logic [W+1:0]  diff;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in the next dividend bit; keep the difference when it does not borrow.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      rem_q <= diff[W+1] ? trial[W-1:0] : diff[W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ rtl/core/animation_time_wrapper.sv @@
// Top level of the animation time wrapper: sequencer, state and datapath.
`default_nettype none

// Animation time wrapper. Each time_now item (signed fixed point, TIME_BITS wide
// inside with FRACTION_BITS fraction bits) yields exactly one result item:
// skip_update and the held scaled time. A sample is a skip when the block is
// inactive, when the time equals the previous one, or when the newly scaled
// time equals the held one. Otherwise, with scaled computation enabled, the
// elapsed time is multiplied by the frequency, added to the weighted time and
// offset by the phase; the result is wrapped by loop, ping-pong reverse or
// clamp mode inside the key range, clamped to that range and mirrored for
// backwards playback. Items are handled one at a time. A skip decided on the
// time alone bypasses the bit-serial multiplier and the bit-serial remainder
// unit; a full update is paced by the multiplier and, when it wraps, by the
// remainder unit, each of which retires one bit per cycle. The finished result
// sits in an output register, so the next item is taken while it waits.
// Configuration writes are taken at any cycle and must only come while idle.
module animation_time_wrapper import atw_pkg::*; #(
  parameter int TIME_BITS     = TIME_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] time_now_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    skip_update_o,
  output logic signed [31:0]      scaled_time_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int W    = TIME_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int EW   = (W > 32) ? W : 32;
  localparam int PW   = 2 * W;
  localparam int PEXT = PW + FB;
  localparam logic [W-1:0]    SBIT      = W'(1) << (W - 1);
  localparam logic [PEXT-1:0] FRAC_MASK = (PEXT'(1) << FB) - PEXT'(1);

  // Sign-extend a 32-bit value, then wrap it to the internal width.
  function automatic logic [W-1:0] from32(logic [31:0] x);
    logic signed [EW-1:0] e;
    e = EW'($signed(x));
    return e[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  function automatic logic lt(logic [W-1:0] a, logic [W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Configuration registers, raw as written.
  logic [31:0] freq_q, phase_q, key_start_q, key_stop_q;
  logic [1:0]  cycle_mode_q;
  logic        play_back_q, active_q, compute_q;

  // Block state.
  logic [W-1:0] prev_q, weighted_q, held_q;

  // Sequencer and datapath.
  atw_state_e   state_q, state_d;
  logic [W-1:0] t_q, delta_q, base_q, mres_q, s_q, span_q, a_q, b_q, r_q;
  logic         neg_q, res_skip_q;
  logic         out_valid_q, out_skip_q;
  logic [31:0]  out_time_q;

  logic [W-1:0]   freq_w, phase_w, start_w, stop_w;
  logic           key_set, wrap_en, mode_loop, mode_rev, first, in_accept, out_load;
  logic           mul_start, mul_done, rem_start, rem_done;
  logic [PW-1:0]  prod;
  logic [PEXT-1:0] prod_ext;
  logic [W-1:0]   prod_sh, rem;
  logic           sticky;
  logic [EW-1:0]  held_ext;

  assign freq_w    = from32(freq_q);
  assign phase_w   = from32(phase_q);
  assign start_w   = from32(key_start_q);
  assign stop_w    = from32(key_stop_q);
  assign key_set   = (key_stop_q != KEY_STOP_UNSET) && (key_start_q != KEY_START_UNSET);
  assign mode_loop = (cycle_mode_q == MODE_WRAP);
  assign mode_rev  = (cycle_mode_q == MODE_PINGPONG);
  assign wrap_en   = key_set && (mode_loop || mode_rev);
  assign first     = (prev_q == SBIT);
  assign in_accept = in_valid_i && in_ready_o;

  // Floor shift of the signed product: negate as ~q plus one unless bits fell off.
  assign prod_ext = PEXT'(prod);
  assign prod_sh  = prod_ext[FB +: W];
  assign sticky   = |(prod_ext & FRAC_MASK);

  atw_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mag(delta_q)),
    .mplier_i(mag(freq_w)),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  atw_rem #(.W(W)) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(mag(a_q)),
    .divisor_i (mag(b_q)),
    .done_o    (rem_done),
    .rem_o     (rem)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q       <= '0;
      phase_q      <= '0;
      key_start_q  <= KEY_START_UNSET;
      key_stop_q   <= KEY_STOP_UNSET;
      cycle_mode_q <= MODE_WRAP;
      play_back_q  <= 1'b0;
      active_q     <= 1'b1;
      compute_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (atw_cfg_idx_e'(cfg_index_i))
        CFG_FREQUENCY:      freq_q       <= cfg_data_i;
        CFG_PHASE:          phase_q      <= cfg_data_i;
        CFG_KEY_START:      key_start_q  <= cfg_data_i;
        CFG_KEY_STOP:       key_stop_q   <= cfg_data_i;
        CFG_CYCLE_MODE:     cycle_mode_q <= cfg_data_i[1:0];
        CFG_PLAY_BACKWARDS: play_back_q  <= cfg_data_i[0];
        CFG_ACTIVE:         active_q     <= cfg_data_i[0];
        CFG_COMPUTE_SCALED: compute_q    <= cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and unit starts.
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    rem_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!active_q || (prev_q == t_q) || !compute_q) state_d = S_DONE;
        else state_d = S_MSETUP;
      end
      S_MSETUP: begin
        mul_start = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (mul_done) state_d = S_MFIX;
      end
      S_MFIX:  state_d = S_WACC;
      S_WACC:  state_d = S_PHASE;
      S_PHASE: state_d = S_WSEL;
      S_WSEL: begin
        if (!wrap_en || (span_q == '0)) state_d = S_CLAMP;
        else state_d = S_DSETUP;
      end
      S_DSETUP: begin
        // A double span that wraps to zero uses the value unreduced.
        if (mode_rev && (b_q == '0)) begin
          state_d = S_POST1;
        end else begin
          rem_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) state_d = S_RSIGN;
      end
      S_RSIGN: state_d = S_POST1;
      S_POST1: state_d = S_POST2;
      S_POST2: state_d = S_POST3;
      S_POST3: state_d = S_CLAMP;
      S_CLAMP: begin
        if (play_back_q) state_d = S_MIR1;
        else state_d = S_CMP;
      end
      S_MIR1: state_d = S_MIR2;
      S_MIR2: state_d = S_CMP;
      S_CMP:  state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Block state: previous time, weighted time and held scaled time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= SBIT;
      weighted_q <= '0;
      held_q     <= '0;
    end else begin
      if (state_q == S_CHECK && active_q && (prev_q != t_q) && compute_q) prev_q <= t_q;
      if (state_q == S_WACC) weighted_q <= base_q + mres_q;
      if (state_q == S_CMP && (s_q != held_q)) held_q <= s_q;
    end
  end

  // Datapath, with its adds and compares spread over the sequencer steps.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) t_q <= from32(time_now_i);
      end
      S_CHECK: begin
        res_skip_q <= !active_q || (prev_q == t_q);
        delta_q    <= first ? '0 : (t_q - prev_q);
        base_q     <= first ? '0 : weighted_q;
      end
      S_MSETUP: neg_q <= delta_q[W-1] ^ freq_w[W-1];
      S_MFIX:   mres_q <= neg_q ? (~prod_sh + W'(!sticky)) : prod_sh;
      S_PHASE: begin
        s_q    <= weighted_q + phase_w;
        span_q <= stop_w - start_w;
      end
      S_WSEL: begin
        if (wrap_en && (span_q == '0)) s_q <= start_w;
        a_q <= mode_loop ? (s_q - start_w) : s_q;
        b_q <= mode_loop ? span_q : {span_q[W-2:0], 1'b0};
      end
      S_DSETUP: r_q <= a_q;
      S_RSIGN:  r_q <= a_q[W-1] ? (~rem + W'(1)) : rem;
      S_POST1: begin
        if (mode_loop) s_q <= r_q + start_w;
        else if (r_q[W-1]) r_q <= r_q + b_q;
      end
      S_POST2: begin
        if (mode_loop) begin
          if (lt(s_q, start_w)) s_q <= s_q + span_q;
        end else if (lt(span_q, r_q)) begin
          r_q <= b_q - r_q;
        end
      end
      S_POST3: begin
        if (mode_rev) s_q <= r_q + start_w;
      end
      S_CLAMP: begin
        // The stop bound wins when the range is inverted.
        if (lt(stop_w, s_q)) s_q <= stop_w;
        else if (lt(s_q, start_w)) s_q <= start_w;
      end
      S_MIR1: s_q <= s_q - start_w;
      S_MIR2: s_q <= stop_w - s_q;
      S_CMP:  res_skip_q <= (s_q == held_q);
      default: ;
    endcase
  end

  // Output register: hold the item until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign held_ext = EW'(held_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_skip_q <= res_skip_q;
      out_time_q <= held_ext[31:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign skip_update_o = out_skip_q;
  assign scaled_time_o = $signed(out_time_q);

`ifndef NO_ASSERTIONS
  // One item at a time: after an acceptance the input side closes.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

  // The held scaled time changes only at the compare step.
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CMP |=> $stable(held_q))
    else $error("held scaled time changed outside the compare step");

  // A result appears only on leaving the done step.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done step");

  // A multiplier start is always followed by the multiply step.
  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> state_q == S_MUL)
    else $error("multiplier started out of sequence");
`endif

endmodule

`default_nettype wire

@@ tb/sv/animation_time_wrapper_tb.sv @@
// Self-checking testbench for the animation time wrapper: directed corners, then random streams.
`timescale 1ns / 100ps

module animation_time_wrapper_tb;
  import atw_pkg::*;

  // Mode code 3 has no package name; the block treats it like clamp.
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  // "No previous time" marker held in the last-time register after reset.
  localparam logic [31:0] NO_TIME     = 32'h8000_0000;
  // Cycles with no handshake on either side before the run is declared hung.
  // It must exceed the slowest item and the longest deliberate output hold.
  localparam int          STALL_LIMIT = 4000;
  // Longest full update plus margin, used for the quiet period at the end.
  localparam int          DRAIN_CYCLES = 100;
  localparam int          MAX_PRINTS  = 40;

  typedef struct packed {
    logic [31:0] frequency;
    logic [31:0] phase;
    logic [31:0] key_start;
    logic [31:0] key_stop;
    logic [1:0]  cycle_mode;
    logic        play_backwards;
    logic        active;
    logic        compute_scaled;
  } settings_t;

  typedef struct packed {
    logic [31:0] time_in;
    logic        skip;
    logic [31:0] scaled;
  } sample_result_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] time_now_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        skip_update_o;
  logic [31:0] scaled_time_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Shadow copy of the block: live register settings and the three state words.
  settings_t   live_settings;
  logic [31:0] last_time_seen   = NO_TIME;
  logic [31:0] weighted_acc     = '0;
  logic [31:0] held_scaled_time = '0;

  // Expected result items, oldest first.
  sample_result_t awaited_updates[$];

  // Traffic shaping knobs: idle and stall chances in percent per cycle, and a receiver hold-off request.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  logic [31:0] sample_clock = '0;
  int error_count    = 0;
  int items_sent     = 0;
  int settings_count = 0;
  int skips_seen     = 0;
  int updates_seen   = 0;
  int quiet_cycles   = 0;

  always #10 clk_i = ~clk_i;

  animation_time_wrapper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .time_now_i   (time_now_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .skip_update_o(skip_update_o),
    .scaled_time_o(scaled_time_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Truncated remainder: magnitude remainder, sign taken from the dividend.
  function automatic logic [31:0] trunc_rem(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    r  = ma % mb;
    return a[31] ? -r : r;
  endfunction

  // Advance the shadow state by one time sample and return the result it causes.
  function automatic sample_result_t predict_time_step(input logic [31:0] t);
    logic [31:0]        delta, s, start, stop, span, dspan, f;
    logic signed [63:0] d64, f64, product;
    sample_result_t     r;
    r.time_in = t;
    r.skip    = 1'b0;
    if (!live_settings.active || last_time_seen == t) begin
      r.skip = 1'b1;
    end else if (live_settings.compute_scaled) begin
      if (last_time_seen == NO_TIME) begin
        weighted_acc = '0;
        delta        = '0;
      end else begin
        delta = t - last_time_seen;
      end
      // Exact product, floor shift by the fraction width, keep the low word.
      d64          = $signed(delta);
      f64          = $signed(live_settings.frequency);
      product      = d64 * f64;
      weighted_acc = weighted_acc + product[47:16];
      s            = weighted_acc + live_settings.phase;
      last_time_seen = t;
      start = live_settings.key_start;
      stop  = live_settings.key_stop;

      // Wrap only when both ends of the key range are set.
      if (stop != KEY_STOP_UNSET && start != KEY_START_UNSET) begin
        span = stop - start;
        if (live_settings.cycle_mode == MODE_WRAP) begin
          if (span != '0) begin
            s = trunc_rem(s - start, span) + start;
            if ($signed(s) < $signed(start)) s = s + span;
          end else begin
            s = start;
          end
        end else if (live_settings.cycle_mode == MODE_PINGPONG) begin
          if (span != '0) begin
            dspan = span << 1;
            // A double span that wraps to zero leaves the phase unreduced.
            f = (dspan != '0) ? trunc_rem(s, dspan) : s;
            if (f[31]) f = f + dspan;
            if ($signed(span) < $signed(f)) s = dspan - f + start;
            else s = f + start;
          end else begin
            s = start;
          end
        end
      end

      // Stop bound is tested first, which matters for an inverted range.
      if ($signed(stop) < $signed(s)) s = stop;
      else if ($signed(s) < $signed(start)) s = start;

      if (live_settings.play_backwards) s = stop - (s - start);

      if (s == held_scaled_time) r.skip = 1'b1;
      else held_scaled_time = s;
    end
    r.scaled = held_scaled_time;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic settings_t make_settings(
    input logic [31:0] frequency, input logic [31:0] phase,
    input logic [31:0] key_start, input logic [31:0] key_stop,
    input logic [1:0] cycle_mode, input logic play_backwards,
    input logic active, input logic compute_scaled);
    settings_t s;
    s.frequency      = frequency;
    s.phase          = phase;
    s.key_start      = key_start;
    s.key_stop       = key_stop;
    s.cycle_mode     = cycle_mode;
    s.play_backwards = play_backwards;
    s.active         = active;
    s.compute_scaled = compute_scaled;
    return s;
  endfunction

  function automatic settings_t random_settings();
    settings_t   s;
    logic [31:0] base, span;
    case ($urandom_range(3))
      0:       s.frequency = $urandom_range(32'h0002_0000);
      1:       s.frequency = -$urandom_range(32'h0002_0000);
      2:       s.frequency = $urandom();
      default: s.frequency = 32'h0001_0000;
    endcase
    if ($urandom_range(1)) s.phase = $urandom_range(32'h0004_0000) - 32'h0002_0000;
    else s.phase = $urandom();
    base = $urandom_range(32'h0008_0000) - 32'h0004_0000;
    span = $urandom_range(32'h0004_0000, 1);
    case ($urandom_range(7))
      0: begin
        s.key_start = KEY_START_UNSET;
        s.key_stop  = KEY_STOP_UNSET;
      end
      1: begin
        s.key_start = KEY_START_UNSET;
        s.key_stop  = base;
      end
      2: begin
        s.key_start = base;
        s.key_stop  = KEY_STOP_UNSET;
      end
      3: begin
        s.key_start = base;
        s.key_stop  = base;
      end
      4: begin
        s.key_start = base + span;
        s.key_stop  = base;
      end
      5: begin
        s.key_start = $urandom();
        s.key_stop  = $urandom();
      end
      6: begin
        // Half-circle span: doubling it wraps to zero.
        s.key_start = base;
        s.key_stop  = base + 32'h8000_0000;
      end
      default: begin
        s.key_start = base;
        s.key_stop  = base + span;
      end
    endcase
    s.cycle_mode     = 2'($urandom_range(3));
    s.play_backwards = 1'($urandom_range(1));
    s.active         = ($urandom_range(9) != 0);
    s.compute_scaled = ($urandom_range(9) != 0);
    return s;
  endfunction

  // Mostly small forward steps, with repeats, backward steps and jumps mixed in.
  function automatic logic [31:0] next_sample_time();
    case ($urandom_range(19))
      0:       sample_clock = sample_clock;
      1:       sample_clock = $urandom();
      2:       sample_clock = sample_clock - $urandom_range(32'h0002_0000, 1);
      default: sample_clock = sample_clock + $urandom_range(32'h0002_0000, 1);
    endcase
    return sample_clock;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offer one time sample; valid stays high across back-to-back items.
  task automatic offer_time_sample(input logic [31:0] t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_now_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_updates.push_back(predict_time_step(t));
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_for_updates();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_updates.size() != 0);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic put_reg(input atw_cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Write all eight registers while idle. Narrow registers get random upper
  // bits, which the block must ignore.
  task automatic apply_settings(input settings_t s);
    logic [31:0] narrow;
    wait_for_updates();
    put_reg(CFG_FREQUENCY, s.frequency);
    put_reg(CFG_PHASE, s.phase);
    put_reg(CFG_KEY_START, s.key_start);
    put_reg(CFG_KEY_STOP, s.key_stop);
    narrow = $urandom();
    narrow[1:0] = s.cycle_mode;
    put_reg(CFG_CYCLE_MODE, narrow);
    narrow = $urandom();
    narrow[0] = s.play_backwards;
    put_reg(CFG_PLAY_BACKWARDS, narrow);
    narrow = $urandom();
    narrow[0] = s.active;
    put_reg(CFG_ACTIVE, narrow);
    narrow = $urandom();
    narrow[0] = s.compute_scaled;
    put_reg(CFG_COMPUTE_SCALED, narrow);
    cfg_we_i <= 1'b0;
    live_settings = s;
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: no previous time, unset range, zero frequency.
  task automatic test_startup_sentinel();
    offer_time_sample(NO_TIME);       // equals the no-previous marker: skip
    offer_time_sample(32'h0000_0000); // first real sample restarts weighting
    offer_time_sample(32'h7FFF_FFFF); // zero frequency: scaled time unchanged
    offer_time_sample(32'h7FFF_FFFF); // same time again
  endtask

  task automatic test_cycle_modes();
    apply_settings(make_settings(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0003_0000,
                                 MODE_WRAP, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h0010_0000);
    offer_time_sample(32'h0011_8000);
    offer_time_sample(32'h0013_0000);
    apply_settings(make_settings(32'h0002_0000, 32'h0000_8000, 32'h0001_0000,
                                 32'h0003_0000, MODE_PINGPONG, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h0014_4000);
    offer_time_sample(32'h0015_8000);
    offer_time_sample(32'h0016_C000);
    apply_settings(make_settings(32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'h0001_0000,
                                 MODE_HOLD, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h0018_0000);
    offer_time_sample(32'h001C_0000);
    // Spare mode with extreme frequency and phase; the minimum time resets
    // the previous-time record, so the sample after it restarts weighting.
    apply_settings(make_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                 32'h0004_0000, MODE_SPARE, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h7FFF_FFFF);
    offer_time_sample(NO_TIME);
    offer_time_sample(32'h0000_0000);
  endtask

  task automatic test_range_corners();
    // Inverted range with mirroring and the most negative frequency.
    apply_settings(make_settings(32'h8000_0000, 32'h0001_0000, 32'h0003_0000,
                                 32'h0001_0000, MODE_WRAP, 1'b1, 1'b1, 1'b1));
    offer_time_sample(32'h0002_0000);
    offer_time_sample(32'h0002_4000);
    // Zero span in loop and in reverse mode.
    apply_settings(make_settings(32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0005_0000,
                                 MODE_WRAP, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h0003_0000);
    apply_settings(make_settings(32'h0001_0000, 32'h0, 32'hFFFB_0000, 32'hFFFB_0000,
                                 MODE_PINGPONG, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h0004_0000);
    // Half-circle span: the doubled span wraps to zero.
    apply_settings(make_settings(32'h0001_0000, 32'h1234_5678, 32'hC000_0000,
                                 32'h4000_0000, MODE_PINGPONG, 1'b0, 1'b1, 1'b1));
    offer_time_sample(32'h0005_0000);
    offer_time_sample(32'h7000_0000);
  endtask

  task automatic test_gating();
    apply_settings(make_settings(32'h0001_0000, 32'h0, 32'h0, 32'h0010_0000,
                                 MODE_WRAP, 1'b0, 1'b0, 1'b1));
    offer_time_sample(32'h0100_0000);
    offer_time_sample(32'h0101_0000);
    apply_settings(make_settings(32'h0001_0000, 32'h0, 32'h0, 32'h0010_0000,
                                 MODE_WRAP, 1'b0, 1'b1, 1'b0));
    offer_time_sample(32'h0102_0000);
    offer_time_sample(32'h0102_0000);
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // output register fills and the block stalls its input.
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_settings(make_settings(32'h0001_8000, 32'h0, 32'h0, 32'h0004_0000,
                                 MODE_PINGPONG, 1'b0, 1'b1, 1'b1));
    hold_request = 300;
    repeat (40) offer_time_sample(next_sample_time());
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (12) begin
      apply_settings(random_settings());
      repeat (31) offer_time_sample(next_sample_time());
    end
  endtask

  task automatic finish_run();
    wait_for_updates();
    // Quiet period: any stray result shows up as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_updates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_updates.size()));
    $display("Ran %0d time samples under %0d register settings with idle and stall mixes",
             items_sent, settings_count);
    $display("Checked %0d skip results and %0d scaled-time updates, %0d mismatches",
             skips_seen, updates_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Processes
  // ---------------------------------------------------------------------------

  // Receiver: random stalls, plus a counted hold-off when a test asks for one.
  initial begin
    int held;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        out_ready_i <= 1'b0;
        repeat (held) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    sample_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected result skip=%0b scaled=%h",
                                  skip_update_o, scaled_time_o));
      end else begin
        want = awaited_updates.pop_front();
        if (want.skip) skips_seen++;
        else updates_seen++;
        if (skip_update_o !== want.skip)
          report_mismatch($sformatf("time %h: skip_update %b, want %b",
                                    want.time_in, skip_update_o, want.skip));
        if (scaled_time_o !== want.scaled)
          report_mismatch($sformatf("time %h: scaled_time %h, want %h",
                                    want.time_in, scaled_time_o, want.scaled));
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset once, directed corners, hold-off, then random phases.
  initial begin
    live_settings = make_settings(32'h0, 32'h0, KEY_START_UNSET, KEY_STOP_UNSET,
                                  MODE_WRAP, 1'b0, 1'b1, 1'b1);
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    time_now_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_FREQUENCY;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_startup_sentinel();
    test_cycle_modes();
    test_range_corners();
    test_gating();
    test_output_holdoff();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(16, 16);
    finish_run();
  end

endmodule

@@ animation_time_wrapper.f @@
rtl/core/atw_pkg.sv
rtl/core/atw_mul.sv
rtl/core/atw_rem.sv
rtl/core/animation_time_wrapper.sv
tb/sv/animation_time_wrapper_tb.sv
